/* rtl/core/jsu_pkg.sv */
package jsu_pkg;

  localparam int MAX_RES = 4;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  localparam logic [1:0] ST_CLOSED   = 2'd0;
  localparam logic [1:0] ST_NO_QUOTE = 2'd1;
  localparam logic [1:0] ST_UNTERM   = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] status;
    logic       last;
  } res_t;

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.string_done = 1'b0;
    r.status      = ST_CLOSED;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_done(input logic [1:0] st);
    res_t r;
    r.out_byte    = 8'h00;
    r.byte_valid  = 1'b0;
    r.string_done = 1'b1;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/core/jsu_if.sv */
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  output status, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  input status, input last, output ready);
endinterface

/* rtl/core/jsu_decode.sv */
module jsu_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic [7:0]                     text_byte,
  input  logic                           end_of_text,
  output jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] res,
  output logic [jsu_pkg::RES_CNT_W-1:0]  res_cnt
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    MODE_EXPECT,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX,
    MODE_AFTER
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [7:0]  pend_r [3];
  logic [7:0]  pend_nxt [3];

  logic [7:0]  tail [3];
  logic [1:0]  tail_len;
  logic        finished;
  logic        stop;
  logic        esc;
  logic [RES_CNT_W-1:0] cnt;

  function automatic logic [7:0] esc_map(input logic [7:0] e);
    case (e)
      8'h6E:   return 8'h0A;
      8'h74:   return 8'h09;
      8'h72:   return 8'h0D;
      8'h62:   return 8'h08;
      8'h66:   return 8'h0C;
      default: return e;
    endcase
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] h);
    if (h >= 8'h30 && h <= 8'h39) return 4'(h - 8'h30);
    if (h >= 8'h61 && h <= 8'h66) return 4'(h - 8'h57);
    if (h >= 8'h41 && h <= 8'h46) return 4'(h - 8'h37);
    return 4'd0;
  endfunction

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tail[j] = (2'(j) < hex_cnt_r) ? pend_r[j] : text_byte;
    end
    tail_len = hex_cnt_r + 2'd1;
  end

  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    pend_nxt    = pend_r;
    res         = '0;
    cnt         = '0;
    finished    = 1'b0;
    stop        = 1'b0;
    esc         = 1'b0;

    case (mode_r)
      MODE_EXPECT: begin
        if (text_byte != CH_QUOTE) begin
          res[cnt[1:0]] = mk_done(ST_NO_QUOTE); cnt = cnt + 1'b1;
          finished = 1'b1;
        end else if (end_of_text) begin
          res[cnt[1:0]] = mk_done(ST_UNTERM); cnt = cnt + 1'b1;
          finished = 1'b1;
        end else begin
          mode_nxt = MODE_BODY;
        end
      end
      MODE_BODY: begin
        if (text_byte == CH_QUOTE) begin
          res[cnt[1:0]] = mk_done(ST_CLOSED); cnt = cnt + 1'b1;
          finished = 1'b1;
        end else if (text_byte == CH_BSL && !end_of_text) begin
          mode_nxt = MODE_ESC;
        end else begin
          res[cnt[1:0]] = mk_byte(text_byte); cnt = cnt + 1'b1;
          if (end_of_text) begin
            res[cnt[1:0]] = mk_done(ST_UNTERM); cnt = cnt + 1'b1;
            finished = 1'b1;
          end
        end
      end
      MODE_ESC: begin
        if (text_byte == CH_U) begin
          hex_cnt_nxt = 2'd0;
          cp_nxt      = 16'h0000;
          mode_nxt    = MODE_HEX;
        end else begin
          res[cnt[1:0]] = mk_byte(esc_map(text_byte)); cnt = cnt + 1'b1;
          mode_nxt = MODE_BODY;
        end
        if (end_of_text) begin
          res[cnt[1:0]] = mk_done(ST_UNTERM); cnt = cnt + 1'b1;
          finished = 1'b1;
        end
      end
      MODE_HEX: begin
        if (end_of_text && hex_cnt_r != 2'd3) begin
          // re-read the gathered digits plus this byte as plain string text
          for (int j = 0; j < 3; j++) begin
            if (2'(j) < tail_len && !stop) begin
              if (esc) begin
                if (tail[j] != CH_U) begin
                  res[cnt[1:0]] = mk_byte(esc_map(tail[j])); cnt = cnt + 1'b1;
                end
                esc = 1'b0;
              end else if (tail[j] == CH_QUOTE) begin
                res[cnt[1:0]] = mk_done(ST_CLOSED); cnt = cnt + 1'b1;
                stop = 1'b1;
              end else if (tail[j] == CH_BSL && 2'(j + 1) < tail_len) begin
                esc = 1'b1;
              end else begin
                res[cnt[1:0]] = mk_byte(tail[j]); cnt = cnt + 1'b1;
              end
            end
          end
          if (!stop) begin
            res[cnt[1:0]] = mk_done(ST_UNTERM); cnt = cnt + 1'b1;
          end
          finished = 1'b1;
        end else begin
          cp_nxt = {cp_r[11:0], hex_val(text_byte)};
          if (hex_cnt_r != 2'd3) begin
            pend_nxt[hex_cnt_r] = text_byte;
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end else begin
            if (cp_nxt < 16'h0080) begin
              res[cnt[1:0]] = mk_byte(cp_nxt[7:0]); cnt = cnt + 1'b1;
            end else if (cp_nxt < 16'h0800) begin
              res[cnt[1:0]] = mk_byte(8'hC0 | {3'b000, cp_nxt[10:6]}); cnt = cnt + 1'b1;
              res[cnt[1:0]] = mk_byte(8'h80 | {2'b00, cp_nxt[5:0]}); cnt = cnt + 1'b1;
            end else begin
              res[cnt[1:0]] = mk_byte(8'hE0 | {4'h0, cp_nxt[15:12]}); cnt = cnt + 1'b1;
              res[cnt[1:0]] = mk_byte(8'h80 | {2'b00, cp_nxt[11:6]}); cnt = cnt + 1'b1;
              res[cnt[1:0]] = mk_byte(8'h80 | {2'b00, cp_nxt[5:0]}); cnt = cnt + 1'b1;
            end
            hex_cnt_nxt = 2'd0;
            mode_nxt    = MODE_BODY;
            if (end_of_text) begin
              res[cnt[1:0]] = mk_done(ST_UNTERM); cnt = cnt + 1'b1;
              finished = 1'b1;
            end
          end
        end
      end
      default: begin
        if (end_of_text) mode_nxt = MODE_EXPECT;
      end
    endcase

    if (finished) mode_nxt = end_of_text ? MODE_EXPECT : MODE_AFTER;

    if (cnt != '0) res[2'(cnt - 1'b1)].last = 1'b1;
    res_cnt = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_EXPECT;
      hex_cnt_r <= 2'd0;
      cp_r      <= 16'h0000;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

  // digit bytes are read only after they were written
  always_ff @(posedge clk) begin
    if (fire) pend_r <= pend_nxt;
  end

endmodule

/* rtl/core/json_string_unescaper_core.sv */
// Channel | Dir | Fields                                             | Handshake
// in_s    | in  | text_byte[7:0], end_of_text                        | valid/ready
// out_s   | out | out_byte[7:0], byte_valid, string_done, status, last | valid/ready
//
// A text byte is registered on accept and decoded from that register into 0 to 4
// results, which load into a 4-entry result buffer; the first result shows on
// out_s in the cycle after the load. One byte per cycle is sustained while each
// byte gives at most one result and out_s stays ready; a byte that gives more
// results holds the input while the buffer drains. Reset (rst_n low, synchronous)
// empties both stages and returns the decoder to waiting for an opening quote.
// Back pressure on out_s stalls the buffer and then in_s.
module json_string_unescaper_core (
  input  logic clk,
  input  logic rst_n,
  jsu_in_if.sink    in_s,
  jsu_out_if.source out_s
);
  import jsu_pkg::*;

  logic                 item_valid_r;
  logic [7:0]           item_byte_r;
  logic                 item_end_r;

  res_t                 buf_r [MAX_RES];
  logic [RES_CNT_W-1:0] cnt_r;

  res_t [MAX_RES-1:0]   dec_res;
  logic [RES_CNT_W-1:0] dec_cnt;

  logic                 pop;
  logic                 space;
  logic                 load;
  logic                 in_fire;

  assign pop     = (cnt_r != '0) && out_s.ready;
  assign space   = (cnt_r == '0) || (cnt_r == RES_CNT_W'(1) && out_s.ready);
  assign load    = item_valid_r && space;
  assign in_s.ready = !item_valid_r || load;
  assign in_fire = in_s.valid && in_s.ready;

  jsu_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (load),
    .text_byte   (item_byte_r),
    .end_of_text (item_end_r),
    .res         (dec_res),
    .res_cnt     (dec_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_fire) begin
      item_valid_r <= 1'b1;
    end else if (load) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_byte_r <= in_s.text_byte;
      item_end_r  <= in_s.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= dec_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // replace on load, otherwise shift toward the head on each transaction
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) buf_r[i] <= dec_res[i];
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) buf_r[i] <= buf_r[i + 1];
    end
  end

  assign out_s.valid       = (cnt_r != '0);
  assign out_s.out_byte    = buf_r[0].out_byte;
  assign out_s.byte_valid  = buf_r[0].byte_valid;
  assign out_s.string_done = buf_r[0].string_done;
  assign out_s.status      = buf_r[0].status;
  assign out_s.last        = buf_r[0].last;

endmodule

/* rtl/core/jsu_checker.sv */
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       string_done,
  input logic [1:0] status,
  input logic       last
);
  import jsu_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_done |-> last && !byte_valid)
    else $error("done marker not the final result of its byte");

  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_valid |-> status == ST_CLOSED && !string_done)
    else $error("decoded byte carries a status");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

endmodule

bind json_string_unescaper_core jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_s.valid),
  .out_ready   (out_s.ready),
  .out_byte    (out_s.out_byte),
  .byte_valid  (out_s.byte_valid),
  .string_done (out_s.string_done),
  .status      (out_s.status),
  .last        (out_s.last)
);

/* dv/tb_json_string_unescaper_core.sv */
module tb_json_string_unescaper_core;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = "u";
  localparam int         RANDOM_ITEMS = 360;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         MAX_PRINTS   = 40;

  localparam res_t R_NONE    = '0;
  localparam res_t R_NOQUOTE = '{8'h00, 1'b0, 1'b1, ST_NO_QUOTE, 1'b1};
  localparam res_t R_CLOSED  = '{8'h00, 1'b0, 1'b1, ST_CLOSED, 1'b1};
  localparam res_t R_UNTERM  = '{8'h00, 1'b0, 1'b1, ST_UNTERM, 1'b1};

  typedef enum logic [2:0] {
    DM_EXPECT, DM_BODY, DM_ESC, DM_HEX, DM_AFTER
  } dec_mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       eot;
    logic       typed;
    res_t       exp;
  } text_item_t;

  // Directed text; rows with typed set carry their single expected result.
  text_item_t directed_rows [26] = '{
    '{"A",       1'b0, 1'b1, R_NOQUOTE},
    '{"x",       1'b1, 1'b0, R_NONE},
    '{CH_QUOTE,  1'b0, 1'b0, R_NONE},
    '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ST_CLOSED, 1'b1}},
    '{8'hFF,     1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, ST_CLOSED, 1'b1}},
    '{CH_BSLASH, 1'b0, 1'b0, R_NONE},
    '{"n",       1'b0, 1'b1, '{8'h0A, 1'b1, 1'b0, ST_CLOSED, 1'b1}},
    '{CH_BSLASH, 1'b0, 1'b0, R_NONE},
    '{CH_U,      1'b0, 1'b0, R_NONE},
    '{"F",       1'b0, 1'b0, R_NONE},
    '{"f",       1'b0, 1'b0, R_NONE},
    '{"F",       1'b0, 1'b0, R_NONE},
    '{"f",       1'b0, 1'b0, R_NONE},
    '{CH_QUOTE,  1'b1, 1'b1, R_CLOSED},
    '{CH_QUOTE,  1'b0, 1'b0, R_NONE},
    '{CH_BSLASH, 1'b1, 1'b0, R_NONE},
    '{CH_QUOTE,  1'b0, 1'b0, R_NONE},
    '{CH_BSLASH, 1'b0, 1'b0, R_NONE},
    '{CH_U,      1'b1, 1'b1, R_UNTERM},
    '{CH_QUOTE,  1'b0, 1'b0, R_NONE},
    '{CH_BSLASH, 1'b0, 1'b0, R_NONE},
    '{CH_U,      1'b0, 1'b0, R_NONE},
    '{CH_QUOTE,  1'b0, 1'b0, R_NONE},
    '{CH_BSLASH, 1'b1, 1'b0, R_NONE},
    '{CH_QUOTE,  1'b0, 1'b0, R_NONE},
    '{"a",       1'b1, 1'b0, R_NONE}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       tx_valid = 1'b0;
  logic [7:0] tx_byte = 8'h00;
  logic       tx_eot = 1'b0;
  logic       rx_ready = 1'b0;

  jsu_in_if  in_s ();
  jsu_out_if out_s ();

  assign in_s.valid       = tx_valid;
  assign in_s.text_byte   = tx_byte;
  assign in_s.end_of_text = tx_eot;
  assign out_s.ready      = rx_ready;

  json_string_unescaper_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .out_s (out_s)
  );

  always #1 clk = ~clk;

  text_item_t text_q [$];
  res_t       decoded_q [$];
  res_t       step_res [$];

  dec_mode_e  dmode = DM_EXPECT;
  logic [1:0] hex_cnt = 2'd0;
  logic [15:0] cpoint = 16'h0000;
  logic [7:0] hex_raw [3];

  int unsigned err_count = 0;
  int unsigned accept_idx = 0;
  int unsigned n_results = 0;
  int unsigned n_bytes = 0;
  int unsigned n_ends = 0;
  int unsigned n_stalls = 0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %h, want %h",
                                n_results, name, got, want));
  endtask

  function automatic void emit_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.status     = ST_CLOSED;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void emit_done(input logic [1:0] st);
    res_t r;
    r = '0;
    r.string_done = 1'b1;
    r.status      = st;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic logic [7:0] unescape_char(input logic [7:0] e);
    case (e)
      "n":     return 8'h0A;
      "t":     return 8'h09;
      "r":     return 8'h0D;
      "b":     return 8'h08;
      "f":     return 8'h0C;
      default: return e;
    endcase
  endfunction

  // Decode one text byte into step_res, advancing the predicted decoder state.
  task automatic decode_text_byte(input logic [7:0] c, input logic eot);
    logic       done_now;
    logic       closed;
    logic [7:0] tail [4];
    logic [7:0] t;
    logic [3:0] nib;
    int         tn;
    int         k;
    done_now = 1'b0;
    step_res.delete();
    case (dmode)
      DM_EXPECT: begin
        if (c != CH_QUOTE) begin
          emit_done(ST_NO_QUOTE);
          done_now = 1'b1;
        end else if (eot) begin
          emit_done(ST_UNTERM);
          done_now = 1'b1;
        end else begin
          dmode = DM_BODY;
        end
      end
      DM_BODY: begin
        if (c == CH_QUOTE) begin
          emit_done(ST_CLOSED);
          done_now = 1'b1;
        end else if (c == CH_BSLASH && !eot) begin
          dmode = DM_ESC;
        end else begin
          emit_byte(c);
          if (eot) begin
            emit_done(ST_UNTERM);
            done_now = 1'b1;
          end
        end
      end
      DM_ESC: begin
        if (c == CH_U) begin
          hex_cnt = 2'd0;
          cpoint  = 16'h0000;
          dmode   = DM_HEX;
        end else begin
          emit_byte(unescape_char(c));
          dmode = DM_BODY;
        end
        if (eot) begin
          emit_done(ST_UNTERM);
          done_now = 1'b1;
        end
      end
      DM_HEX: begin
        if (eot && hex_cnt != 2'd3) begin
          // text ended mid-escape: decode the gathered digits as plain string text
          tn = int'(hex_cnt);
          for (k = 0; k < tn; k++) tail[k] = hex_raw[k];
          tail[tn] = c;
          tn++;
          k = 0;
          closed = 1'b0;
          while (k < tn && !closed) begin
            t = tail[k];
            k++;
            if (t == CH_QUOTE) begin
              emit_done(ST_CLOSED);
              closed = 1'b1;
            end else if (t == CH_BSLASH && k < tn) begin
              t = tail[k];
              k++;
              if (t != CH_U) emit_byte(unescape_char(t));
            end else begin
              emit_byte(t);
            end
          end
          if (!closed) emit_done(ST_UNTERM);
          done_now = 1'b1;
        end else begin
          if (c >= "0" && c <= "9")      nib = 4'(c - "0");
          else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
          else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
          else                           nib = 4'h0;
          cpoint = {cpoint[11:0], nib};
          if (hex_cnt != 2'd3) begin
            hex_raw[hex_cnt] = c;
            hex_cnt = hex_cnt + 2'd1;
          end else begin
            if (cpoint < 16'h0080) begin
              emit_byte(cpoint[7:0]);
            end else if (cpoint < 16'h0800) begin
              emit_byte({3'b110, cpoint[10:6]});
              emit_byte({2'b10, cpoint[5:0]});
            end else begin
              emit_byte({4'b1110, cpoint[15:12]});
              emit_byte({2'b10, cpoint[11:6]});
              emit_byte({2'b10, cpoint[5:0]});
            end
            hex_cnt = 2'd0;
            dmode = DM_BODY;
            if (eot) begin
              emit_done(ST_UNTERM);
              done_now = 1'b1;
            end
          end
        end
      end
      default: begin
        if (eot) dmode = DM_EXPECT;
      end
    endcase
    if (done_now) dmode = eot ? DM_EXPECT : DM_AFTER;
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endtask

  // Stimulus building

  task automatic add_text(input logic [7:0] b, input logic eot);
    text_item_t it;
    it = '0;
    it.text_byte = b;
    it.eot       = eot;
    text_q.insert(text_q.size(), it);
  endtask

  function automatic logic [7:0] hex_digit_char(input logic [3:0] v);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(0, 1) ? "a" : "A") + v - 8'd10;
  endfunction

  // Digit bytes that stress the end-of-text replay of a short hex escape.
  function automatic logic [7:0] tail_char();
    case ($urandom_range(0, 6))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_U;
      3:       return "n";
      4, 5:    return hex_digit_char(4'($urandom_range(0, 15)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  // Append one text; returns the number of bytes appended, less any trailing bytes after the closing quote.
  task automatic gen_text(output int unsigned counted);
    string       esc_set;
    logic [15:0] cp;
    int unsigned n_elem;
    int unsigned len;
    int unsigned i;
    int unsigned start;
    esc_set = "ntrbf\"\\/";
    start = text_q.size();
    if ($urandom_range(0, 99) < 12) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++)
        add_text(8'($urandom_range(0, 255)),
                 (i == len - 1) || ($urandom_range(0, 3) == 0));
      counted = len;
      return;
    end
    add_text(CH_QUOTE, 1'b0);
    n_elem = $urandom_range(0, 7);
    for (i = 0; i < n_elem; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_text(plain_char(), 1'b0);
        5, 6: begin
          add_text(CH_BSLASH, 1'b0);
          if ($urandom_range(0, 2) != 0) add_text(esc_set[$urandom_range(0, 7)], 1'b0);
          else add_text(plain_char() == CH_U ? "q" : plain_char(), 1'b0);
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
            1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          endcase
          add_text(CH_BSLASH, 1'b0);
          add_text(CH_U, 1'b0);
          add_text(hex_digit_char(cp[15:12]), 1'b0);
          add_text(hex_digit_char(cp[11:8]), 1'b0);
          add_text(hex_digit_char(cp[7:4]), 1'b0);
          add_text(hex_digit_char(cp[3:0]), 1'b0);
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if ($urandom_range(0, 1)) begin
          add_text(CH_QUOTE, 1'b1);
          counted = text_q.size() - start;
        end else begin
          add_text(CH_QUOTE, 1'b0);
          counted = text_q.size() - start;
          // trailing bytes after the close are skipped until end of text
          len = $urandom_range(0, 3);
          for (i = 0; i < len; i++) add_text(8'($urandom_range(0, 255)), 1'b0);
          add_text(8'($urandom_range(0, 255)), 1'b1);
        end
        return;
      end
      5: add_text(plain_char(), 1'b1);
      6: add_text(CH_BSLASH, 1'b1);
      7: begin
        add_text(CH_BSLASH, 1'b0);
        add_text(8'($urandom_range(0, 255)), 1'b1);
      end
      8: begin
        add_text(CH_BSLASH, 1'b0);
        add_text(CH_U, 1'b0);
        len = $urandom_range(0, 2);
        for (i = 0; i < len; i++) add_text(tail_char(), 1'b0);
        add_text(tail_char(), 1'b1);
      end
      default: begin
        add_text(CH_BSLASH, 1'b0);
        add_text(CH_U, 1'b0);
        for (i = 0; i < 3; i++)
          add_text(hex_digit_char(4'($urandom_range(0, 15))), 1'b0);
        add_text(hex_digit_char(4'($urandom_range(0, 15))), 1'b1);
      end
    endcase
    counted = text_q.size() - start;
  endtask

  // Input monitor: predict the results of each accepted text byte
  always @(posedge clk) begin
    if (rst_n && in_s.valid && in_s.ready) begin
      decode_text_byte(in_s.text_byte, in_s.end_of_text);
      if (text_q[accept_idx].typed) begin
        decoded_q.insert(decoded_q.size(), text_q[accept_idx].exp);
      end else begin
        foreach (step_res[i]) decoded_q.insert(decoded_q.size(), step_res[i]);
      end
      accept_idx++;
    end
  end

  // Output monitor: compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_s.valid && out_s.ready) begin
      got = '{out_s.out_byte, out_s.byte_valid, out_s.string_done, out_s.status, out_s.last};
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", got.out_byte, want.out_byte);
        check_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
        check_field("string_done", 8'(got.string_done), 8'(want.string_done));
        check_field("status", 8'(got.status), 8'(want.status));
        check_field("last", 8'(got.last), 8'(want.last));
      end
      n_results++;
      if (got.byte_valid) n_bytes++;
      if (got.string_done) n_ends++;
    end
  end

  // Receiver back pressure: a rotating ready pattern, re-chosen every window
  logic [7:0]  ready_pat = 8'hFF;
  int unsigned ready_win = 0;

  always @(posedge clk) begin
    logic [7:0] pat;
    pat = ready_pat;
    if (ready_win == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    pat = 8'hFF;
        2:       pat = 8'($urandom_range(0, 255));
        3:       pat = 8'b1110_1110;
        default: pat = 8'b1000_0000;
      endcase
      ready_win <= $urandom_range(8, 60);
    end else begin
      ready_win <= ready_win - 1;
    end
    ready_pat <= {pat[6:0], pat[7]};
    rx_ready  <= pat[7];
    if (rst_n && out_s.valid && !out_s.ready) n_stalls++;
  end

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned rand_count;
    int unsigned got_n;
    foreach (directed_rows[i]) text_q.insert(text_q.size(), directed_rows[i]);
    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      gen_text(got_n);
      rand_count += got_n;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    foreach (text_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        if (gap != 0) begin
          tx_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      tx_valid <= 1'b1;
      tx_byte  <= text_q[i].text_byte;
      tx_eot   <= text_q[i].eot;
      @(posedge clk);
      while (!in_s.ready) @(posedge clk);
      burst_left--;
    end
    tx_valid <= 1'b0;

    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    foreach (decoded_q[i]) report_mismatch($sformatf("missing result %h", decoded_q[i]));
    $display("Decoded %0d text bytes into %0d results (%0d string bytes, %0d string ends);",
             accept_idx, n_results, n_bytes, n_ends);
    $display("receiver held off %0d cycles with results waiting.", n_stalls);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results still expected", decoded_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
